>>> hdl/dwc_pkg.sv
// shared types and constants of the depthwise convolution block
package dwc_pkg;

  localparam int MAX_DIM_DEF    = 32;
  localparam int MAX_KERNEL_DEF = 5;
  localparam int QUEUE_DEPTH    = 2;

  localparam int ROW_W  = 5;
  localparam int DATA_W = 16;
  localparam int CFG_W  = 6;
  localparam int IDX_W  = 2;

  localparam logic [1:0] FUNC_LOAD_PIX = 2'd0;
  localparam logic [1:0] FUNC_LOAD_WT  = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE  = 2'd2;

  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_KERNEL = 2'd2;
  localparam logic [IDX_W-1:0] REG_STRIDE = 2'd3;

  typedef enum logic [1:0] {
    KIND_PIX,
    KIND_WT,
    KIND_CONV,
    KIND_ERR
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   col;
    logic [DATA_W-1:0]  data;
  } entry_t;

  typedef struct packed {
    logic [5:0] h;
    logic [5:0] w;
    logic [2:0] k;
    logic [2:0] s;
    logic [1:0] pad;
    logic [6:0] oh;
    logic [6:0] ow;
  } geom_t;

endpackage

>>> hdl/dwc_front.sv
// front end: accepts input transfers, classifies them and feeds the queue
module dwc_front #(
  parameter int MAX_DIM    = dwc_pkg::MAX_DIM_DEF,
  parameter int MAX_KERNEL = dwc_pkg::MAX_KERNEL_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dwc_pkg::geom_t              geo,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [dwc_pkg::ROW_W-1:0]   in_row,
  input  logic [dwc_pkg::ROW_W-1:0]   in_col,
  input  logic [dwc_pkg::DATA_W-1:0]  in_data,
  output logic                        push_valid,
  input  logic                        push_ready,
  output dwc_pkg::entry_t             push_entry
);

  logic            fvalid;
  dwc_pkg::entry_t fentry;
  logic            keep;
  dwc_pkg::kind_t  kind;

  always_comb begin
    keep = 1'b0;
    kind = dwc_pkg::KIND_PIX;
    case (in_func)
      dwc_pkg::FUNC_LOAD_PIX: begin
        kind = dwc_pkg::KIND_PIX;
        keep = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
      end
      dwc_pkg::FUNC_LOAD_WT: begin
        kind = dwc_pkg::KIND_WT;
        keep = (32'(in_row) < MAX_KERNEL) && (32'(in_col) < MAX_KERNEL);
      end
      dwc_pkg::FUNC_COMPUTE: begin
        keep = 1'b1;
        if ((7'(in_row) >= geo.oh) || (7'(in_col) >= geo.ow)) begin
          kind = dwc_pkg::KIND_ERR;
        end else begin
          kind = dwc_pkg::KIND_CONV;
        end
      end
      default: begin
        keep = 1'b0;
        kind = dwc_pkg::KIND_PIX;
      end
    endcase
  end

  assign in_ready   = !fvalid || push_ready;
  assign push_valid = fvalid;
  assign push_entry = fentry;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else begin
      if (in_valid && in_ready && keep) begin
        fvalid <= 1'b1;
      end else if (fvalid && push_ready) begin
        fvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && keep) begin
      fentry.kind <= kind;
      fentry.row  <= in_row;
      fentry.col  <= in_col;
      fentry.data <= in_data;
    end
  end

endmodule

>>> hdl/dwc_queue.sv
// short queue between front end and compute engine
module dwc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  dwc_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  logic            pop,
  output dwc_pkg::entry_t pop_entry
);

  localparam int PTR_W = (dwc_pkg::QUEUE_DEPTH > 1) ? $clog2(dwc_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(dwc_pkg::QUEUE_DEPTH + 1);

  dwc_pkg::entry_t  slots [dwc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (32'(count) != dwc_pkg::QUEUE_DEPTH);
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (32'(wptr) == dwc_pkg::QUEUE_DEPTH - 1) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (32'(rptr) == dwc_pkg::QUEUE_DEPTH - 1) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_entry;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (32'(count) == dwc_pkg::QUEUE_DEPTH) && !do_pop |=> 32'(count) == dwc_pkg::QUEUE_DEPTH)
    else $error("queue lost an entry while full");

  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !do_pop)
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count out of step with pushes");

endmodule

>>> hdl/dwc_back.sv
// compute engine: local stores, tap sequencer, multiply-accumulate and result register
module dwc_back #(
  parameter int MAX_DIM    = dwc_pkg::MAX_DIM_DEF,
  parameter int MAX_KERNEL = dwc_pkg::MAX_KERNEL_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dwc_pkg::geom_t              geo,
  input  logic                        q_valid,
  input  dwc_pkg::entry_t             q_entry,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dwc_pkg::DATA_W-1:0]  out_value,
  output logic                        out_sat,
  output logic                        out_err,
  output logic [5:0]                  out_h,
  output logic [5:0]                  out_w
);

  localparam int PIX_DEPTH = MAX_DIM * MAX_DIM;
  localparam int WT_DEPTH  = MAX_KERNEL * MAX_KERNEL;
  localparam int PAW       = $clog2(PIX_DEPTH);
  localparam int WAW       = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
  localparam int KCW       = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int ACC_W     = 33 + $clog2(WT_DEPTH);
  localparam int Q_W       = ACC_W - 14;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t state;

  logic signed [dwc_pkg::DATA_W-1:0] pix_mem [PIX_DEPTH];
  logic signed [dwc_pkg::DATA_W-1:0] wt_mem  [WT_DEPTH];

  logic [dwc_pkg::ROW_W-1:0] row;
  logic [dwc_pkg::ROW_W-1:0] col;
  logic [KCW-1:0]            kh;
  logic [KCW-1:0]            kw;

  logic [7:0]     rs;
  logic [7:0]     cs;
  logic [9:0]     ih;
  logic [9:0]     iw;
  logic           inb;
  logic           issue;
  logic           last_kw;
  logic           last_kh;
  logic [PAW-1:0] pix_raddr;
  logic [WAW-1:0] wt_raddr;
  logic [PAW-1:0] pix_waddr;
  logic [WAW-1:0] wt_waddr;
  logic           pix_we;
  logic           wt_we;

  logic                              v1;
  logic                              inb1;
  logic signed [dwc_pkg::DATA_W-1:0] rd_pix;
  logic signed [dwc_pkg::DATA_W-1:0] rd_wt;
  logic                              v2;
  logic signed [31:0]                prod;
  logic signed [ACC_W-1:0]           acc;

  logic [ACC_W-1:0] rounded;
  logic [Q_W-1:0]   q;
  logic             fits;
  logic [15:0]      res_value;

  logic out_free;
  logic load_err;
  logic load_done;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    q_pop = 1'b0;
    if (state == S_IDLE && q_valid) begin
      case (q_entry.kind)
        dwc_pkg::KIND_PIX:  q_pop = 1'b1;
        dwc_pkg::KIND_WT:   q_pop = 1'b1;
        dwc_pkg::KIND_CONV: q_pop = 1'b1;
        dwc_pkg::KIND_ERR:  q_pop = out_free;
        default:            q_pop = 1'b0;
      endcase
    end
  end

  assign pix_we    = q_pop && (q_entry.kind == dwc_pkg::KIND_PIX);
  assign wt_we     = q_pop && (q_entry.kind == dwc_pkg::KIND_WT);
  assign pix_waddr = PAW'(32'(q_entry.row) * MAX_DIM + 32'(q_entry.col));
  assign wt_waddr  = WAW'(32'(q_entry.row) * MAX_KERNEL + 32'(q_entry.col));
  assign load_err  = q_pop && (q_entry.kind == dwc_pkg::KIND_ERR);

  // tap address generation
  assign rs        = 8'(row) * 8'(geo.s);
  assign cs        = 8'(col) * 8'(geo.s);
  assign ih        = 10'(rs) - 10'(geo.pad) + 10'(kh);
  assign iw        = 10'(cs) - 10'(geo.pad) + 10'(kw);
  assign inb       = !ih[9] && !iw[9] && (ih < 10'(geo.h)) && (iw < 10'(geo.w));
  assign pix_raddr = PAW'(32'(ih) * MAX_DIM + 32'(iw));
  assign wt_raddr  = WAW'(32'(kh) * MAX_KERNEL + 32'(kw));
  assign issue     = (state == S_RUN);
  assign last_kw   = (32'(kw) == 32'(geo.k) - 32'd1);
  assign last_kh   = (32'(kh) == 32'(geo.k) - 32'd1);

  // round half up to q8.8 and clip
  assign rounded   = acc + ACC_W'(8192);
  assign q         = rounded[ACC_W-1:14];
  assign fits      = (q[Q_W-1:15] == '0) || (q[Q_W-1:15] == '1);
  assign res_value = fits ? q[15:0] : (q[Q_W-1] ? 16'h8000 : 16'h7fff);
  assign load_done = (state == S_DRAIN) && !v1 && !v2 && out_free;

  always_ff @(posedge clk) begin
    if (pix_we) begin
      pix_mem[pix_waddr] <= q_entry.data;
    end
    rd_pix <= pix_mem[pix_raddr];
  end

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= q_entry.data;
    end
    rd_wt <= wt_mem[wt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      case (state)
        S_IDLE: begin
          if (q_pop && q_entry.kind == dwc_pkg::KIND_CONV) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (last_kw && last_kh) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (load_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    inb1 <= inb;
    prod <= inb1 ? rd_pix * rd_wt : 32'sd0;
    if (q_pop && q_entry.kind == dwc_pkg::KIND_CONV) begin
      row <= q_entry.row;
      col <= q_entry.col;
      kh  <= '0;
      kw  <= '0;
      acc <= '0;
    end else begin
      if (issue) begin
        if (last_kw) begin
          kw <= '0;
          kh <= kh + 1'b1;
        end else begin
          kw <= kw + 1'b1;
        end
      end
      if (v2) begin
        acc <= acc + {{(ACC_W-32){prod[31]}}, prod};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (load_err || load_done) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      out_value <= '0;
      out_sat   <= 1'b0;
      out_err   <= 1'b1;
      out_h     <= geo.oh[5:0];
      out_w     <= geo.ow[5:0];
    end else if (load_done) begin
      out_value <= res_value;
      out_sat   <= !fits;
      out_err   <= 1'b0;
      out_h     <= geo.oh[5:0];
      out_w     <= geo.ow[5:0];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !v1 && !v2)
    else $error("mac pipeline busy while engine idle");

  assert property (@(posedge clk) disable iff (rst)
    v1 |-> $past(state == S_RUN))
    else $error("tap read issued outside run");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DRAIN) || $past(state == S_IDLE))
    else $error("result loaded in wrong state");

endmodule

>>> hdl/depthwise_conv_padded_strided_top.sv
// top level: configuration registers, geometry, front end, queue and compute engine
// a load transfer is written to its local store as it is popped from the queue
// an out-of-range compute loads an error result once the output register is free
// an in-range compute runs one multiply-accumulate per tap, then drains its pipeline
// a two-entry queue lets input transfers continue while the engine is busy
// synchronous reset clears control state and sets height 8, width 8, kernel 3, stride 1
module depthwise_conv_padded_strided_top #(
  parameter int MAX_DIM    = dwc_pkg::MAX_DIM_DEF,
  parameter int MAX_KERNEL = dwc_pkg::MAX_KERNEL_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [dwc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [dwc_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // row_index, col_index, data_value
  input  logic [1:0]                 s_axis_tuser,  // func
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata   // conv_value, saturated, coord_error,
                                                    // out_height, out_width
);

  logic [5:0] image_height;
  logic [5:0] image_width;
  logic [2:0] kernel_size;
  logic [2:0] stride_step;

  dwc_pkg::geom_t geo;
  logic [5:0]     num_h;
  logic [5:0]     num_w;
  logic [5:0]     quo_h;
  logic [5:0]     quo_w;

  logic            push_valid;
  logic            push_ready;
  dwc_pkg::entry_t push_entry;
  logic            q_valid;
  logic            q_pop;
  dwc_pkg::entry_t q_entry;

  logic [15:0] out_value;
  logic        out_sat;
  logic        out_err;
  logic [5:0]  out_h;
  logic [5:0]  out_w;

  function automatic logic [5:0] div_step(input logic [5:0] num, input logic [2:0] s);
    logic [12:0] prod;
    prod = 13'(num) * 13'd43;
    case (s)
      3'd1:    div_step = num;
      3'd2:    div_step = num >> 1;
      3'd3:    div_step = prod[12:7];
      default: div_step = num >> 2;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      image_height <= 6'd8;
      image_width  <= 6'd8;
      kernel_size  <= 3'd3;
      stride_step  <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        dwc_pkg::REG_HEIGHT: image_height <= cfg_data;
        dwc_pkg::REG_WIDTH:  image_width  <= cfg_data;
        dwc_pkg::REG_KERNEL: kernel_size  <= cfg_data[2:0];
        dwc_pkg::REG_STRIDE: stride_step  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geo.h = (image_height == '0) ? 6'd1 :
            ((32'(image_height) > MAX_DIM) ? 6'(MAX_DIM) : image_height);
    geo.w = (image_width == '0) ? 6'd1 :
            ((32'(image_width) > MAX_DIM) ? 6'(MAX_DIM) : image_width);
    geo.k = (kernel_size == '0) ? 3'd1 :
            ((32'(kernel_size) > MAX_KERNEL) ? 3'(MAX_KERNEL) : kernel_size);
    geo.s = (stride_step == '0) ? 3'd1 : ((stride_step > 3'd4) ? 3'd4 : stride_step);
    geo.pad = geo.k[2:1];
    // h + 2*pad - k is h for even kernels and h - 1 for odd ones
    num_h  = geo.h - 6'(geo.k[0]);
    num_w  = geo.w - 6'(geo.k[0]);
    quo_h  = div_step(num_h, geo.s);
    quo_w  = div_step(num_w, geo.s);
    geo.oh = 7'(quo_h) + 7'd1;
    geo.ow = 7'(quo_w) + 7'd1;
  end

  dwc_front #(
    .MAX_DIM    (MAX_DIM),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .geo        (geo),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_func    (s_axis_tuser),
    .in_row     (s_axis_tdata[4:0]),
    .in_col     (s_axis_tdata[9:5]),
    .in_data    (s_axis_tdata[25:10]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  dwc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  dwc_back #(
    .MAX_DIM    (MAX_DIM),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .geo       (geo),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (out_value),
    .out_sat   (out_sat),
    .out_err   (out_err),
    .out_h     (out_h),
    .out_w     (out_w)
  );

  assign m_axis_tdata = {2'b00, out_w, out_h, out_err, out_sat, out_value};

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the depthwise convolution block, predicted results checked per transfer
module testbench;

  localparam int PIX_SIDE    = 32;
  localparam int TAP_SIDE    = 5;
  localparam int SETTLE      = 64;
  localparam int ITEM_TARGET = 1100;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct {
    logic [1:0]  func;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [15:0] data;
  } conv_req_t;

  typedef struct {
    logic [15:0] value;
    logic        sat;
    logic        err;
    logic [5:0]  oh;
    logic [5:0]  ow;
  } conv_res_t;

  typedef struct {
    int h;
    int w;
    int k;
    int s;
    int pad;
    int oh;
    int ow;
  } shape_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // row_index, col_index, data_value
  logic [1:0]  s_axis_tuser = '0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // conv_value, saturated, coord_error, out_height, out_width

  logic [5:0] reg_height = 6'd8;
  logic [5:0] reg_width  = 6'd8;
  logic [2:0] reg_kernel = 3'd3;
  logic [2:0] reg_stride = 3'd1;

  logic signed [15:0] image_pixels [PIX_SIDE*PIX_SIDE];
  logic signed [15:0] kernel_taps  [TAP_SIDE*TAP_SIDE];
  bit                 pix_loaded   [PIX_SIDE*PIX_SIDE];
  bit                 tap_loaded   [TAP_SIDE*TAP_SIDE];

  conv_req_t pending_reqs [$];
  conv_req_t in_flight;
  conv_res_t expected_results [$];

  int send_idle_pct = 8;
  int recv_idle_pct = 65;
  int queued = 0;
  int accepted = 0;
  int mismatches = 0;
  int cycles = 0;

  depthwise_conv_padded_strided_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic shape_t current_shape();
    shape_t g;
    g.h   = clamp_int(int'(reg_height), 1, PIX_SIDE);
    g.w   = clamp_int(int'(reg_width), 1, PIX_SIDE);
    g.k   = clamp_int(int'(reg_kernel), 1, TAP_SIDE);
    g.s   = clamp_int(int'(reg_stride), 1, 4);
    g.pad = g.k / 2;
    g.oh  = (g.h + 2 * g.pad - g.k) / g.s + 1;
    g.ow  = (g.w + 2 * g.pad - g.k) / g.s + 1;
    return g;
  endfunction

  function automatic logic [15:0] pick_data();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3, 4: return 16'(int'($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void queue_req(logic [1:0] f, int r, int c, logic [15:0] d);
    conv_req_t q;
    q.func = f;
    q.row  = r[4:0];
    q.col  = c[4:0];
    q.data = d;
    pending_reqs.push_back(q);
    queued++;
    if (f == dwc_pkg::FUNC_LOAD_PIX) pix_loaded[r*PIX_SIDE + c] = 1'b1;
    if (f == dwc_pkg::FUNC_LOAD_WT && r < TAP_SIDE && c < TAP_SIDE)
      tap_loaded[r*TAP_SIDE + c] = 1'b1;
  endfunction

  // loads any window entry not yet written, then asks for the output pixel
  function automatic void queue_compute(int r, int c);
    shape_t g;
    int ih;
    int iw;
    g = current_shape();
    if (r < g.oh && c < g.ow) begin
      for (int kh = 0; kh < g.k; kh++) begin
        for (int kw = 0; kw < g.k; kw++) begin
          ih = r * g.s - g.pad + kh;
          iw = c * g.s - g.pad + kw;
          if (ih >= 0 && ih < g.h && iw >= 0 && iw < g.w) begin
            if (!pix_loaded[ih*PIX_SIDE + iw])
              queue_req(dwc_pkg::FUNC_LOAD_PIX, ih, iw, pick_data());
            if (!tap_loaded[kh*TAP_SIDE + kw])
              queue_req(dwc_pkg::FUNC_LOAD_WT, kh, kw, pick_data());
          end
        end
      end
    end
    queue_req(dwc_pkg::FUNC_COMPUTE, r, c, 16'($urandom));
  endfunction

  function automatic void depthwise_step(conv_req_t q);
    shape_t g;
    conv_res_t r;
    longint acc;
    longint q14;
    int ih;
    int iw;
    case (q.func)
      dwc_pkg::FUNC_LOAD_PIX: image_pixels[int'(q.row)*PIX_SIDE + int'(q.col)] = q.data;
      dwc_pkg::FUNC_LOAD_WT: begin
        if (q.row < TAP_SIDE && q.col < TAP_SIDE)
          kernel_taps[int'(q.row)*TAP_SIDE + int'(q.col)] = q.data;
      end
      dwc_pkg::FUNC_COMPUTE: begin
        g = current_shape();
        r.oh = g.oh[5:0];
        r.ow = g.ow[5:0];
        r.value = '0;
        r.sat = 1'b0;
        r.err = 1'b0;
        if (int'(q.row) >= g.oh || int'(q.col) >= g.ow) begin
          r.err = 1'b1;
        end else begin
          acc = 0;
          for (int kh = 0; kh < g.k; kh++) begin
            for (int kw = 0; kw < g.k; kw++) begin
              ih = int'(q.row) * g.s - g.pad + kh;
              iw = int'(q.col) * g.s - g.pad + kw;
              if (ih >= 0 && ih < g.h && iw >= 0 && iw < g.w)
                acc += longint'(image_pixels[ih*PIX_SIDE + iw]) *
                       longint'(kernel_taps[kh*TAP_SIDE + kw]);
            end
          end
          // round half up, floor shift of Q10.22 down to Q8.8
          q14 = (acc + 64'sd8192) >>> 14;
          if (q14 > 32767) begin
            q14 = 32767;
            r.sat = 1'b1;
          end else if (q14 < -32768) begin
            q14 = -32768;
            r.sat = 1'b1;
          end
          r.value = q14[15:0];
        end
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic settle();
    do @(posedge clk);
    while (accepted != queued || expected_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic set_geometry(logic [5:0] h, logic [5:0] w, logic [2:0] k, logic [2:0] s);
    settle();
    reg_height = h;
    reg_width  = w;
    reg_kernel = k;
    reg_stride = s;
    write_reg(dwc_pkg::REG_HEIGHT, h);
    write_reg(dwc_pkg::REG_WIDTH, w);
    write_reg(dwc_pkg::REG_KERNEL, {3'b000, k});
    write_reg(dwc_pkg::REG_STRIDE, {3'b000, s});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        depthwise_step(in_flight);
        accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_flight = pending_reqs.pop_front();
          s_axis_tdata  <= {6'd0, in_flight.data, in_flight.col, in_flight.row};
          s_axis_tuser  <= in_flight.func;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    conv_res_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: %h", m_axis_tdata);
          mismatches++;
        end else begin
          e = expected_results.pop_front();
          if (m_axis_tdata[15:0] !== e.value) begin
            $error("conv_value expected %0d got %0d", $signed(e.value),
                   $signed(m_axis_tdata[15:0]));
            mismatches++;
          end
          if (m_axis_tdata[16] !== e.sat) begin
            $error("saturated expected %0d got %0d", e.sat, m_axis_tdata[16]);
            mismatches++;
          end
          if (m_axis_tdata[17] !== e.err) begin
            $error("coord_error expected %0d got %0d", e.err, m_axis_tdata[17]);
            mismatches++;
          end
          if (m_axis_tdata[23:18] !== e.oh) begin
            $error("out_height expected %0d got %0d", e.oh, m_axis_tdata[23:18]);
            mismatches++;
          end
          if (m_axis_tdata[29:24] !== e.ow) begin
            $error("out_width expected %0d got %0d", e.ow, m_axis_tdata[29:24]);
            mismatches++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[depthwise_conv_padded_strided_top] ERROR");
      $finish;
    end
  end

  initial begin
    shape_t g;
    int sel;
    int r;
    int c;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset geometry 8x8, kernel 3, stride 1
    for (int kh = 0; kh < 3; kh++)
      for (int kw = 0; kw < 3; kw++)
        queue_req(dwc_pkg::FUNC_LOAD_WT, kh, kw, 16'h7fff);
    for (int i = 0; i < 4; i++) queue_req(dwc_pkg::FUNC_LOAD_PIX, i / 2, i % 2, 16'h7fff);
    queue_compute(0, 0);
    for (int i = 0; i < 4; i++) queue_req(dwc_pkg::FUNC_LOAD_PIX, i / 2, i % 2, 16'h8000);
    queue_compute(0, 0);
    queue_compute(7, 7);
    queue_compute(8, 3);
    queue_compute(31, 31);
    queue_req(FUNC_NONE, 31, 31, 16'hffff);
    queue_req(dwc_pkg::FUNC_LOAD_WT, 5, 0, 16'h1234);
    queue_req(dwc_pkg::FUNC_LOAD_WT, 31, 31, 16'hffff);
    queue_req(dwc_pkg::FUNC_LOAD_PIX, 31, 31, 16'h0000);

    // random part, geometry extremes first
    for (int p = 0; queued < ITEM_TARGET; p++) begin
      case (p)
        0: set_geometry(6'd1, 6'd1, 3'd1, 3'd1);
        1: set_geometry(6'd32, 6'd32, 3'd5, 3'd4);
        2: set_geometry(6'd0, 6'd63, 3'd0, 3'd0);
        3: set_geometry(6'd32, 6'd32, 3'd4, 3'd1);
        4: set_geometry(6'd33, 6'd7, 3'd7, 3'd5);
        5: set_geometry(6'd5, 6'd17, 3'd2, 3'd3);
        6: set_geometry(6'd63, 6'd0, 3'd6, 3'd2);
        default: set_geometry(
          6'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 10)),
          6'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 10)),
          3'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5)),
          3'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4)));
      endcase
      if (queued < ITEM_TARGET / 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 65;
      end else if (queued < 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      g = current_shape();
      for (int n = 0; n < 40; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          if ($urandom_range(0, 99) < 85)
            queue_compute($urandom_range(0, clamp_int(g.oh, 1, PIX_SIDE) - 1),
                          $urandom_range(0, clamp_int(g.ow, 1, PIX_SIDE) - 1));
          else
            queue_compute($urandom_range(0, 31), $urandom_range(0, 31));
        end else if (sel < 75) begin
          if ($urandom_range(0, 3) == 0)
            queue_req(dwc_pkg::FUNC_LOAD_PIX, $urandom_range(0, 31), $urandom_range(0, 31),
                      pick_data());
          else
            queue_req(dwc_pkg::FUNC_LOAD_PIX, $urandom_range(0, g.h - 1),
                      $urandom_range(0, g.w - 1), pick_data());
        end else if (sel < 87) begin
          queue_req(dwc_pkg::FUNC_LOAD_WT, $urandom_range(0, g.k - 1),
                    $urandom_range(0, g.k - 1), pick_data());
        end else if (sel < 94) begin
          queue_req(FUNC_NONE, $urandom_range(0, 31), $urandom_range(0, 31), 16'($urandom));
        end else begin
          r = $urandom_range(5, 31);
          c = $urandom_range(0, 31);
          if ($urandom_range(0, 1) == 0)
            queue_req(dwc_pkg::FUNC_LOAD_WT, r, c, 16'($urandom));
          else
            queue_req(dwc_pkg::FUNC_LOAD_WT, c, r, 16'($urandom));
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("[depthwise_conv_padded_strided_top] OK");
    end else begin
      $display("[depthwise_conv_padded_strided_top] ERROR");
    end
    $finish;
  end

endmodule
